FILE: rtl/core/hrc_pkg.sv
package hrc_pkg;

    // Command codes
    localparam logic CMD_HSV2RGB = 1'b0;
    localparam logic CMD_RGB2HSV = 1'b1;

    // Hue scale: 1/64 degree units
    localparam logic [14:0] TURN      = 15'd23040;
    localparam logic [11:0] SECTOR    = 12'd3840;
    localparam logic [14:0] HUE_GREEN = 15'd7680;
    localparam logic [14:0] HUE_BLUE  = 15'd15360;

    // Register stages from accept to result
    localparam int PIPE_DEPTH = 9;

    // Divider: two quotient bits per stage
    localparam int DIV_STAGES = 6;
    localparam int QUO_W      = 2 * DIV_STAGES;

    // Input word
    typedef struct packed {
        logic        command;
        logic [14:0] hue_in;
        logic [7:0]  sat_in;
        logic [7:0]  val_in;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } hrc_in_t;

    // Result word
    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [14:0] hue_out;
        logic [7:0]  sat_out;
        logic [7:0]  val_out;
    } hrc_out_t;

endpackage

FILE: rtl/core/hrc_div.sv
module hrc_div
    import hrc_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [19:0]       num,
    input  logic [7:0]        den,
    output logic [QUO_W-1:0]  quo
);

    typedef struct packed {
        logic [7:0]       rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic [7:0]       den;
    } div_stage_t;

    div_stage_t st_reg  [DIV_STAGES];
    div_stage_t st_next [DIV_STAGES];

    // One restoring step: {new remainder, quotient bit}
    function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
                                            input logic [7:0] d);
        logic [8:0] t;
        logic [8:0] diff;
        t    = {rem, nb};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
            return {diff[7:0], 1'b1};
        return {t[7:0], 1'b0};
    endfunction

    // Each stage retires two quotient bits; high numerator bits start as remainder
    always_comb
    begin
        div_stage_t prev;
        logic [8:0] a;
        logic [8:0] b;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (i == 0)
            begin
                prev.rem = num[19:QUO_W];
                prev.low = num[QUO_W-1:0];
                prev.quo = '0;
                prev.den = den;
            end
            else
            begin
                prev = st_reg[i-1];
            end
            a = div_step(prev.rem, prev.low[QUO_W-1], prev.den);
            b = div_step(a[8:1], prev.low[QUO_W-2], prev.den);
            st_next[i].rem = b[8:1];
            st_next[i].low = {prev.low[QUO_W-3:0], 2'b00};
            st_next[i].quo = {prev.quo[QUO_W-3:0], a[0], b[0]};
            st_next[i].den = prev.den;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                st_reg[i] <= st_next[i];
        end
    end

    assign quo = st_reg[DIV_STAGES-1].quo;

endmodule

FILE: rtl/core/hrc_rgb2hsv.sv
module hrc_rgb2hsv
    import hrc_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic [14:0] hue,
    output logic [7:0]  sat,
    output logic [7:0]  val,
    output logic [7:0]  red_echo,
    output logic [7:0]  green_echo,
    output logic [7:0]  blue_echo
);

    localparam logic [1:0] BASE_RED   = 2'd0;
    localparam logic [1:0] BASE_GREEN = 2'd1;
    localparam logic [1:0] BASE_BLUE  = 2'd2;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic [7:0] diff;
        logic       neg;
        logic [1:0] base;
        logic [7:0] delta;
        logic [7:0] mx;
        rgb_t       echo;
    } s1_t;

    typedef struct packed {
        logic        neg;
        logic [1:0]  base;
        logic        delta_zero;
        logic        mx_zero;
        logic [7:0]  mx;
        rgb_t        echo;
    } side_t;

    typedef struct packed {
        logic [19:0] hnum;
        logic [15:0] snum;
        logic [7:0]  delta;
        side_t       side;
    } s2_t;

    typedef struct packed {
        logic [14:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        rgb_t        echo;
    } fin_t;

    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    side_t side_reg [DIV_STAGES];
    fin_t  fin_reg, fin_next;

    logic [QUO_W-1:0] hue_quo;
    logic [QUO_W-1:0] sat_quo;

    // Stage 1: max, min, dominant channel and signed difference
    always_comb
    begin
        logic [7:0] mx;
        logic [7:0] mn;
        logic [7:0] p;
        logic [7:0] q;
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        if (red == mx)
        begin
            p = green; q = blue; s1_next.base = BASE_RED;
        end
        else if (green == mx)
        begin
            p = blue; q = red; s1_next.base = BASE_GREEN;
        end
        else
        begin
            p = red; q = green; s1_next.base = BASE_BLUE;
        end
        s1_next.neg   = (p < q);
        s1_next.diff  = (p >= q) ? (p - q) : (q - p);
        s1_next.delta = mx - mn;
        s1_next.mx    = mx;
        s1_next.echo  = '{r: red, g: green, b: blue};
    end

    // Stage 2: dividends 3840*diff and 255*delta by shift and subtract
    always_comb
    begin
        s2_next.hnum = {s1_reg.diff, 12'd0} - {4'd0, s1_reg.diff, 8'd0};
        s2_next.snum = {s1_reg.delta, 8'd0} - {8'd0, s1_reg.delta};
        s2_next.delta = s1_reg.delta;
        s2_next.side.neg        = s1_reg.neg;
        s2_next.side.base       = s1_reg.base;
        s2_next.side.delta_zero = (s1_reg.delta == 8'd0);
        s2_next.side.mx_zero    = (s1_reg.mx == 8'd0);
        s2_next.side.mx         = s1_reg.mx;
        s2_next.side.echo       = s1_reg.echo;
    end

    hrc_div u_hue_div (
        .clk (clk),
        .en  (en),
        .num (s2_reg.hnum),
        .den (s2_reg.delta),
        .quo (hue_quo)
    );

    hrc_div u_sat_div (
        .clk (clk),
        .en  (en),
        .num ({4'd0, s2_reg.snum}),
        .den (s2_reg.side.mx),
        .quo (sat_quo)
    );

    // Final: hue offset by sector base; a negative offset from red wraps around the turn
    always_comb
    begin
        side_t       sd;
        logic [14:0] q;
        logic [14:0] base;
        sd = side_reg[DIV_STAGES-1];
        q  = {3'd0, hue_quo};
        case (sd.base)
            BASE_RED:   base = 15'd0;
            BASE_GREEN: base = HUE_GREEN;
            BASE_BLUE:  base = HUE_BLUE;
            default:    base = 15'd0;
        endcase
        if (sd.delta_zero)
            fin_next.hue = 15'd0;
        else if (sd.neg && (q != 15'd0))
            fin_next.hue = (sd.base == BASE_RED) ? (TURN - q) : (base - q);
        else
            fin_next.hue = base + q;
        fin_next.sat  = sd.mx_zero ? 8'd0 : sat_quo[7:0];
        fin_next.val  = sd.mx;
        fin_next.echo = sd.echo;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            side_reg[0] <= s2_reg.side;
            for (int i = 1; i < DIV_STAGES; i++)
                side_reg[i] <= side_reg[i-1];
            fin_reg <= fin_next;
        end
    end

    assign hue        = fin_reg.hue;
    assign sat        = fin_reg.sat;
    assign val        = fin_reg.val;
    assign red_echo   = fin_reg.echo.r;
    assign green_echo = fin_reg.echo.g;
    assign blue_echo  = fin_reg.echo.b;

endmodule

FILE: rtl/core/hrc_hsv2rgb.sv
module hrc_hsv2rgb
    import hrc_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [14:0] hue,
    input  logic [7:0]  sat,
    input  logic [7:0]  val,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [14:0] hue_echo,
    output logic [7:0]  sat_echo,
    output logic [7:0]  val_echo
);

    typedef struct packed {
        logic [14:0] h;
        logic [7:0]  s;
        logic [7:0]  v;
    } hsv_t;

    typedef struct packed {
        hsv_t        echo;
        logic [15:0] prod;
    } h1_t;

    typedef struct packed {
        hsv_t        echo;
        logic [7:0]  c;
        logic [2:0]  sector;
        logic [11:0] frac;
    } h2_t;

    typedef struct packed {
        hsv_t        echo;
        logic [7:0]  c;
        logic [7:0]  m;
        logic [2:0]  sector;
        logic [19:0] work;
    } hw_t;

    typedef struct packed {
        hsv_t        echo;
        logic [7:0]  c;
        logic [7:0]  m;
        logic [2:0]  sector;
        logic [11:0] n;
        logic [7:0]  q0;
    } h5_t;

    typedef struct packed {
        hsv_t        echo;
        logic [7:0]  c;
        logic [7:0]  m;
        logic [2:0]  sector;
        logic [7:0]  x;
    } h6_t;

    typedef struct packed {
        hsv_t        echo;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
    } h7_t;

    h1_t h1_reg, h1_next;
    h2_t h2_reg, h2_next;
    hw_t h3_reg, h3_next;
    hw_t h4_reg, h4_next;
    h5_t h5_reg, h5_next;
    h6_t h6_reg, h6_next;
    h7_t h7_reg, h7_next;
    h7_t pad1_reg, pad2_reg;

    // Stage 1: wrap hue once, v*s
    always_comb
    begin
        h1_next.echo.h = (hue >= TURN) ? (hue - TURN) : hue;
        h1_next.echo.s = sat;
        h1_next.echo.v = val;
        h1_next.prod   = 16'(val) * 16'(sat);
    end

    // Stage 2: c = floor(v*s/255), sector and offset within sector
    always_comb
    begin
        logic [16:0] t;
        logic [14:0] h;
        logic [14:0] base;
        t = {1'b0, h1_reg.prod} + {9'd0, h1_reg.prod[15:8]} + 17'd1;
        h = h1_reg.echo.h;
        if (h >= 15'(5 * SECTOR))
            h2_next.sector = 3'd5;
        else if (h >= 15'(4 * SECTOR))
            h2_next.sector = 3'd4;
        else if (h >= 15'(3 * SECTOR))
            h2_next.sector = 3'd3;
        else if (h >= 15'(2 * SECTOR))
            h2_next.sector = 3'd2;
        else if (h >= 15'(SECTOR))
            h2_next.sector = 3'd1;
        else
            h2_next.sector = 3'd0;
        case (h2_next.sector)
            3'd1:    base = 15'(SECTOR);
            3'd2:    base = 15'(2 * SECTOR);
            3'd3:    base = 15'(3 * SECTOR);
            3'd4:    base = 15'(4 * SECTOR);
            3'd5:    base = 15'(5 * SECTOR);
            default: base = 15'd0;
        endcase
        h2_next.frac = 12'(h - base);
        h2_next.c    = t[15:8];
        h2_next.echo = h1_reg.echo;
    end

    // Stage 3: ramp direction by sector parity, m = v - c
    always_comb
    begin
        h3_next.echo   = h2_reg.echo;
        h3_next.c      = h2_reg.c;
        h3_next.m      = h2_reg.echo.v - h2_reg.c;
        h3_next.sector = h2_reg.sector;
        h3_next.work   = {8'd0, h2_reg.sector[0] ? (SECTOR - h2_reg.frac) : h2_reg.frac};
    end

    // Stage 4: c * ramp
    always_comb
    begin
        h4_next      = h3_reg;
        h4_next.work = 20'(h3_reg.c) * 20'(h3_reg.work[11:0]);
    end

    // Stage 5: /3840 = /256 then /15 by reciprocal (may be one low)
    always_comb
    begin
        logic [11:0] n;
        logic [23:0] k;
        n = h4_reg.work[19:8];
        k = 24'(n) * 24'd4369;
        h5_next.echo   = h4_reg.echo;
        h5_next.c      = h4_reg.c;
        h5_next.m      = h4_reg.m;
        h5_next.sector = h4_reg.sector;
        h5_next.n      = n;
        h5_next.q0     = k[23:16];
    end

    // Stage 6: correct the reciprocal quotient
    always_comb
    begin
        logic [11:0] rr;
        rr = h5_reg.n - {h5_reg.q0, 4'd0} + {4'd0, h5_reg.q0};
        h6_next.echo   = h5_reg.echo;
        h6_next.c      = h5_reg.c;
        h6_next.m      = h5_reg.m;
        h6_next.sector = h5_reg.sector;
        h6_next.x      = (rr >= 12'd15) ? (h5_reg.q0 + 8'd1) : h5_reg.q0;
    end

    // Stage 7: place c and x by sector, add m
    always_comb
    begin
        logic [7:0] r1;
        logic [7:0] g1;
        logic [7:0] b1;
        case (h6_reg.sector)
            3'd0:    begin r1 = h6_reg.c; g1 = h6_reg.x; b1 = 8'd0;     end
            3'd1:    begin r1 = h6_reg.x; g1 = h6_reg.c; b1 = 8'd0;     end
            3'd2:    begin r1 = 8'd0;     g1 = h6_reg.c; b1 = h6_reg.x; end
            3'd3:    begin r1 = 8'd0;     g1 = h6_reg.x; b1 = h6_reg.c; end
            3'd4:    begin r1 = h6_reg.x; g1 = 8'd0;     b1 = h6_reg.c; end
            default: begin r1 = h6_reg.c; g1 = 8'd0;     b1 = h6_reg.x; end
        endcase
        h7_next.echo = h6_reg.echo;
        h7_next.r    = r1 + h6_reg.m;
        h7_next.g    = g1 + h6_reg.m;
        h7_next.b    = b1 + h6_reg.m;
    end

    // Two pad stages match the RGB to HSV latency
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg   <= h1_next;
            h2_reg   <= h2_next;
            h3_reg   <= h3_next;
            h4_reg   <= h4_next;
            h5_reg   <= h5_next;
            h6_reg   <= h6_next;
            h7_reg   <= h7_next;
            pad1_reg <= h7_reg;
            pad2_reg <= pad1_reg;
        end
    end

    assign red      = pad2_reg.r;
    assign green    = pad2_reg.g;
    assign blue     = pad2_reg.b;
    assign hue_echo = pad2_reg.echo.h;
    assign sat_echo = pad2_reg.echo.s;
    assign val_echo = pad2_reg.echo.v;

endmodule

FILE: rtl/core/hsv_rgb_color_converter.sv
// HSV <-> RGB pixel converter, direction chosen per word by command.
// Registered stages from accept to result valid (RGB to HSV path: min/max,
// dividends, 6-stage two-bit-per-stage divider, hue/sat fixup; HSV path padded).
// Throughput: one word per cycle; a stall on the result holds the whole pipe.
// Reset clears the stage valid bits only; data registers are not reset.
module hsv_rgb_color_converter
    import hrc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pixel_valid,
    output logic     pixel_stall,
    input  hrc_in_t  pixel,
    output logic     result_valid,
    input  logic     result_stall,
    output hrc_out_t result
);

    logic [PIPE_DEPTH-1:0] valid_reg, valid_next;
    logic [PIPE_DEPTH-1:0] cmd_reg, cmd_next;
    logic                  en;

    logic [7:0]  h2r_red, h2r_green, h2r_blue;
    logic [14:0] h2r_hue;
    logic [7:0]  h2r_sat, h2r_val;
    logic [14:0] r2h_hue;
    logic [7:0]  r2h_sat, r2h_val;
    logic [7:0]  r2h_red, r2h_green, r2h_blue;

    // Pipe advances unless the last stage holds a stalled word
    assign en          = !valid_reg[PIPE_DEPTH-1] || !result_stall;
    assign pixel_stall = !en;

    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], pixel_valid};
    assign cmd_next   = {cmd_reg[PIPE_DEPTH-2:0], pixel.command};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cmd_reg <= cmd_next;
    end

    hrc_hsv2rgb u_hsv2rgb (
        .clk      (clk),
        .en       (en),
        .hue      (pixel.hue_in),
        .sat      (pixel.sat_in),
        .val      (pixel.val_in),
        .red      (h2r_red),
        .green    (h2r_green),
        .blue     (h2r_blue),
        .hue_echo (h2r_hue),
        .sat_echo (h2r_sat),
        .val_echo (h2r_val)
    );

    hrc_rgb2hsv u_rgb2hsv (
        .clk        (clk),
        .en         (en),
        .red        (pixel.red_in),
        .green      (pixel.green_in),
        .blue       (pixel.blue_in),
        .hue        (r2h_hue),
        .sat        (r2h_sat),
        .val        (r2h_val),
        .red_echo   (r2h_red),
        .green_echo (r2h_green),
        .blue_echo  (r2h_blue)
    );

    // Result select by the command that traveled with the word
    always_comb
    begin
        if (cmd_reg[PIPE_DEPTH-1] == CMD_RGB2HSV)
        begin
            result.red_out   = r2h_red;
            result.green_out = r2h_green;
            result.blue_out  = r2h_blue;
            result.hue_out   = r2h_hue;
            result.sat_out   = r2h_sat;
            result.val_out   = r2h_val;
        end
        else
        begin
            result.red_out   = h2r_red;
            result.green_out = h2r_green;
            result.blue_out  = h2r_blue;
            result.hue_out   = h2r_hue;
            result.sat_out   = h2r_sat;
            result.val_out   = h2r_val;
        end
    end

    assign result_valid = valid_reg[PIPE_DEPTH-1];

endmodule
